[rtl/ccpm_pkg.sv]
// Shared types, constants and register codes of the phase current Clarke/Park measure unit.
`default_nettype none
package ccpm_pkg;

   // Default quarter-wave sine table resolution.
   localparam int SineRomBitsDefault = 10;

   // Field widths.
   localparam int AdcWidth   = 15;
   localparam int AngleWidth = 16;
   localparam int CurWidth   = 16;
   localparam int CsrWidth   = 16;
   localparam int CsrIdxWidth = 2;

   // Stream payload widths, padded to whole bytes.
   localparam int ReqDataWidth = 48;
   localparam int RspDataWidth = 120;

   // Shared multiplier operand and product widths.
   localparam int MulWidth  = 18;
   localparam int ProdWidth = 2 * MulWidth;

   // One over square root of three in Q15.
   localparam logic [CurWidth-1:0] OneBySqrt3 = 16'd18919;

   // Register indexes.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_IU_OFFSET  = 2'd0,
      CSR_IW_OFFSET  = 2'd1,
      CSR_TRIP_LEVEL = 2'd2,
      CSR_FILT_GAIN  = 2'd3
   } csr_index_type;

   // Register reset values.
   localparam logic [14:0] IuOffsetReset  = 15'd16384;
   localparam logic [14:0] IwOffsetReset  = 15'd16384;
   localparam logic [14:0] TripLevelReset = 15'd32767;
   localparam logic [15:0] FiltGainReset  = 16'd6554;

   // Handshake between the sequencer and the square root unit.
   typedef struct packed {
      logic        start;
      logic [33:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] root;
   } sqrt_rsp_type;

endpackage
`default_nettype wire

[rtl/phase_current_clarke_park_measure_unit.sv]
// Top level of the phase current Clarke/Park measure unit.
// One sample is taken per transfer on req_; the block then stays busy while nine products
// run in turn on one shared multiplier, each issued and then taken, and a bit-serial square
// root runs, before the result is offered on rsp_. The next sample is taken as soon as the
// previous result has moved to the output register. The overcurrent fault stays set until
// reset. Registers are to be written on csr_ only while the block is idle; the block itself does not enforce this.
`default_nettype none
module phase_current_clarke_park_measure_unit #(
   parameter int SINE_ROM_BITS = ccpm_pkg::SineRomBitsDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Fields from bit 0: adc_phase_u[14:0], adc_phase_w[29:15], rotor_angle[45:30].
   input  wire logic [ccpm_pkg::ReqDataWidth-1:0]   req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0: current_u, current_v, current_w, current_beta, current_d,
   // current_q, filtered_amplitude (16 bits each), overcurrent_now[112],
   // overcurrent_latched[113].
   output logic [ccpm_pkg::RspDataWidth-1:0]        rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_we,
   input  wire logic [ccpm_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [ccpm_pkg::CsrWidth-1:0]       csr_wdata
);
   import ccpm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ISSUE, ST_TAKE, ST_SQRT, ST_SQRT_WAIT, ST_FINAL
   } state_type;

   // Product schedule of the shared multiplier.
   localparam logic [3:0] OpBetaU = 4'd0;
   localparam logic [3:0] OpBetaV = 4'd1;
   localparam logic [3:0] OpDCos  = 4'd2;
   localparam logic [3:0] OpDSin  = 4'd3;
   localparam logic [3:0] OpQCos  = 4'd4;
   localparam logic [3:0] OpQSin  = 4'd5;
   localparam logic [3:0] OpDSq   = 4'd6;
   localparam logic [3:0] OpQSq   = 4'd7;
   localparam logic [3:0] OpFilt  = 4'd8;

   // Configuration registers.
   logic [14:0] iu_off_ff, iw_off_ff, trip_ff;
   logic [15:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iu_off_ff <= IuOffsetReset;
         iw_off_ff <= IwOffsetReset;
         trip_ff   <= TripLevelReset;
         gain_ff   <= FiltGainReset;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IU_OFFSET:  iu_off_ff <= csr_wdata[14:0];
            CSR_IW_OFFSET:  iw_off_ff <= csr_wdata[14:0];
            CSR_TRIP_LEVEL: trip_ff   <= csr_wdata[14:0];
            CSR_FILT_GAIN:  gain_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Phase currents and overcurrent check on the incoming sample.
   logic [14:0] adc_u, adc_w;
   logic [15:0] angle, cos_angle;
   logic [15:0] du, dw, iu_new, iw_new, iv_new;
   logic signed [15:0] sin_new, cos_new;
   logic        now_new;

   function automatic logic over_trip(input logic [15:0] v, input logic [14:0] lvl);
      logic [16:0] m;
      m = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
      return m > {2'b00, lvl};
   endfunction

   always_comb begin
      adc_u     = req_tdata[14:0];
      adc_w     = req_tdata[29:15];
      angle     = req_tdata[45:30];
      cos_angle = angle + 16'h4000;
      du        = {1'b0, adc_u} - {1'b0, iu_off_ff};
      dw        = {1'b0, adc_w} - {1'b0, iw_off_ff};
      iu_new    = {du[14:0], 1'b0};
      iw_new    = {dw[14:0], 1'b0};
      iv_new    = 16'd0 - (iu_new + iw_new);
      now_new   = over_trip(iu_new, trip_ff) || over_trip(iw_new, trip_ff) ||
                  over_trip(iv_new, trip_ff);
   end

   ccpm_sine_rom #(.SINE_ROM_BITS(SINE_ROM_BITS)) u_sin (.angle(angle), .sine(sin_new));
   ccpm_sine_rom #(.SINE_ROM_BITS(SINE_ROM_BITS)) u_cos (.angle(cos_angle), .sine(cos_new));

   // Shared multiplier.
   logic signed [MulWidth-1:0]  op_a, op_b;
   logic signed [ProdWidth-1:0] product;

   ccpm_mul u_mul (.clock(clock), .op_a(op_a), .op_b(op_b), .product(product));

   // Square root unit.
   sqrt_req_type sreq;
   sqrt_rsp_type srsp;

   ccpm_isqrt u_sqrt (.clock(clock), .reset(reset), .sreq(sreq), .srsp(srsp));

   // Sequencer state and working registers.
   state_type   state_ff, state_in;
   logic [3:0]  op_ff, op_in;
   logic [15:0] iu_ff, iv_ff, iw_ff, beta_ff, d_ff, q_ff;
   logic [15:0] sin_ff, cos_ff;
   logic [15:0] part_ff, part_in;
   logic [32:0] mag2_ff, mag2_in;
   logic [15:0] amp_ff;
   logic [31:0] acc_ff, acc_in;
   logic        now_ff, fault_ff;
   logic [15:0] beta_in, d_in, q_in;
   logic [15:0] amp_in;
   logic [16:0] diff;
   logic [15:0] frac;
   logic        accept;
   logic        rsp_valid_ff;
   logic [RspDataWidth-1:0] rsp_data_ff;

   assign accept = req_tvalid && req_tready;
   assign frac   = product[30:15];
   assign diff   = {1'b0, amp_ff} - {acc_ff[31], acc_ff[31:16]};

   // Operand selection for the current product.
   always_comb begin
      case (op_ff)
         OpBetaU: begin op_a = MulWidth'($signed(iu_ff));   op_b = MulWidth'($signed(OneBySqrt3)); end
         OpBetaV: begin op_a = MulWidth'($signed(iv_ff));   op_b = MulWidth'($signed(OneBySqrt3)); end
         OpDCos:  begin op_a = MulWidth'($signed(iu_ff));   op_b = MulWidth'($signed(cos_ff)); end
         OpDSin:  begin op_a = MulWidth'($signed(beta_ff)); op_b = MulWidth'($signed(sin_ff)); end
         OpQCos:  begin op_a = MulWidth'($signed(beta_ff)); op_b = MulWidth'($signed(cos_ff)); end
         OpQSin:  begin op_a = MulWidth'($signed(iu_ff));   op_b = MulWidth'($signed(sin_ff)); end
         OpDSq:   begin op_a = MulWidth'($signed(d_ff));    op_b = MulWidth'($signed(d_ff)); end
         OpQSq:   begin op_a = MulWidth'($signed(q_ff));    op_b = MulWidth'($signed(q_ff)); end
         OpFilt:  begin op_a = MulWidth'($signed({1'b0, gain_ff})); op_b = MulWidth'($signed(diff)); end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      part_in  = part_ff;
      beta_in  = beta_ff;
      d_in     = d_ff;
      q_in     = q_ff;
      mag2_in  = mag2_ff;
      acc_in   = acc_ff;
      amp_in   = amp_ff;
      sreq.start    = 1'b0;
      sreq.radicand = {1'b0, mag2_ff};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ISSUE;
               op_in    = OpBetaU;
            end
         end
         ST_ISSUE: state_in = ST_TAKE;
         ST_TAKE: begin
            state_in = ST_ISSUE;
            op_in    = op_ff + 4'd1;
            case (op_ff)
               OpBetaU, OpDCos, OpQCos: part_in = frac;
               OpBetaV: beta_in = part_ff + {frac[14:0], 1'b0};
               OpDSin:  d_in    = part_ff + frac;
               OpQSin:  q_in    = part_ff - frac;
               OpDSq:   mag2_in = {1'b0, product[31:0]};
               OpQSq: begin
                  mag2_in  = mag2_ff + {1'b0, product[31:0]};
                  state_in = ST_SQRT;
               end
               OpFilt: begin
                  acc_in   = acc_ff + product[31:0];
                  state_in = ST_FINAL;
               end
               default: ;
            endcase
         end
         ST_SQRT: begin
            sreq.start = 1'b1;
            state_in   = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (srsp.done) begin
               amp_in   = srsp.root[16:15] != 2'b00 ? 16'd32767 : {1'b0, srsp.root[14:0]};
               op_in    = OpFilt;
               state_in = ST_ISSUE;
            end
         end
         ST_FINAL: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer registers, sample capture and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OpBetaU;
         acc_ff       <= '0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         acc_ff   <= acc_in;
         if (accept && now_new) begin
            fault_ff <= 1'b1;
         end
         if (state_ff == ST_FINAL && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         iu_ff  <= iu_new;
         iv_ff  <= iv_new;
         iw_ff  <= iw_new;
         sin_ff <= sin_new;
         cos_ff <= cos_new;
         now_ff <= now_new;
      end
      part_ff <= part_in;
      beta_ff <= beta_in;
      d_ff    <= d_in;
      q_ff    <= q_in;
      mag2_ff <= mag2_in;
      amp_ff  <= amp_in;
      if (state_ff == ST_FINAL && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {6'd0, fault_ff, now_ff, acc_ff[31:16], q_ff, d_ff, beta_ff,
                         iw_ff, iv_ff, iu_ff};
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The fault, once set, stays set until reset.
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(fault_ff) |-> fault_ff) else $error("overcurrent fault cleared");

   // A taken sample keeps the block busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready) else $error("ready right after a transfer");

   // A result that flags overcurrent also shows the latched fault.
   a_now_implies_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[112] |-> rsp_data_ff[113])
      else $error("overcurrent without latched fault");

   // The square root only completes while the sequencer waits for it.
   a_sqrt_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      srsp.done |-> state_ff == ST_SQRT_WAIT) else $error("unexpected root");

endmodule
`default_nettype wire

[rtl/ccpm_sine_rom.sv]
// Quarter-wave sine table with quadrant folding, built at elaboration.
`default_nettype none
module ccpm_sine_rom #(
   parameter int SINE_ROM_BITS = ccpm_pkg::SineRomBitsDefault
) (
   input  wire logic [ccpm_pkg::AngleWidth-1:0]    angle,
   output logic signed [ccpm_pkg::CurWidth-1:0]    sine
);
   import ccpm_pkg::*;

   localparam int RomSize = (1 << SINE_ROM_BITS) + 1;
   localparam int IdxWidth = SINE_ROM_BITS + 1;

   // Integer Q30 Horner evaluation of the sine polynomial, rounded to Q15.
   function automatic logic [14:0] rom_entry(input int k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] v;
      x  = 64'(k) << (30 - SINE_ROM_BITS);
      x2 = (x * x) >> 30;
      p  = 64'd172272;
      p  = 64'd5026995    - ((p * x2) >> 30);
      p  = 64'd85569306   - ((p * x2) >> 30);
      p  = 64'd693598670  - ((p * x2) >> 30);
      p  = 64'd1686629713 - ((p * x2) >> 30);
      s  = (p * x) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

   // Constant table, one entry per quarter-wave step.
   logic [14:0] rom_tbl [0:RomSize-1];

   for (genvar k = 0; k < RomSize; k++) begin : g_rom
      assign rom_tbl[k] = rom_entry(k);
   end

   logic [IdxWidth-1:0] idx;
   logic [14:0]         mag;

   // Mirror in odd quadrants, negate in the lower half circle.
   always_comb begin
      idx = {1'b0, angle[13:14-SINE_ROM_BITS]};
      if (angle[14]) begin
         idx = IdxWidth'(1 << SINE_ROM_BITS) - idx;
      end
      mag = rom_tbl[idx];
      if (angle[15]) begin
         sine = -$signed({1'b0, mag});
      end else begin
         sine = $signed({1'b0, mag});
      end
   end

endmodule
`default_nettype wire

[rtl/ccpm_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none
module ccpm_mul (
   input  wire logic                                  clock,
   input  wire logic signed [ccpm_pkg::MulWidth-1:0]  op_a,
   input  wire logic signed [ccpm_pkg::MulWidth-1:0]  op_b,
   output logic signed [ccpm_pkg::ProdWidth-1:0]      product
);
   import ccpm_pkg::*;

   logic signed [ProdWidth-1:0] prod_ff;

   // One product per cycle, registered.
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign product = prod_ff;

endmodule
`default_nettype wire

[rtl/ccpm_isqrt.sv]
// Bit-serial floor square root, one result bit per cycle.
`default_nettype none
module ccpm_isqrt (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ccpm_pkg::sqrt_req_type sreq,
   output ccpm_pkg::sqrt_rsp_type      srsp
);
   import ccpm_pkg::*;

   logic [33:0] val_ff, val_in;
   logic [19:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [19:0] shifted;
   logic [19:0] trial;

   // One digit step: bring down two bits, try to subtract.
   always_comb begin
      shifted = {rem_ff[17:0], val_ff[33:32]};
      trial   = {1'b0, root_ff, 2'b01};
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (sreq.start) begin
         val_in  = sreq.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 5'd17;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[31:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[15:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign srsp.done = done_ff;
   assign srsp.root = root_ff;

endmodule
`default_nettype wire
